/* rtl/gcr_pkg.sv */
`default_nettype none

package gcr_pkg;

  // Edge store sizing
  localparam int EDGE_CAPACITY = 256;
  localparam int EDGE_AW       = $clog2(EDGE_CAPACITY);
  localparam int CNT_W         = EDGE_AW + 1;

  // Coordinate format: signed, FRACTION_BITS below the binary point
  localparam int FRACTION_BITS = 4;
  localparam int COORD_W       = 16;
  localparam int COL_W         = 10;
  localparam int SHIFT_W       = 11;
  localparam int PIX_W         = 12;
  localparam int SAMP_W        = PIX_W + FRACTION_BITS;
  localparam int DIFF_W        = ((COORD_W > SAMP_W) ? COORD_W : SAMP_W) + 1;
  localparam int ACC_W         = 2 * DIFF_W + 2;

  // Per-sample winding sum, covers +/- the full edge count
  localparam int WIND_W        = CNT_W + 1;
  localparam int COVER_W       = 5;

  // Result fields
  localparam int COV_W         = 8;
  localparam int HELD_W        = 9;
  localparam int HELD_MAX      = 511;

  // Stream widths
  localparam int IN_TDATA_W    = 56;
  localparam int OUT_TDATA_W   = 24;
  localparam int OP_W          = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_POINT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SHIFT_X = 1'b0;
  localparam logic CFG_SHIFT_Y = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_ONE = 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    point_t upper;
    point_t lower;
    logic   rises;
  } edge_t;

  typedef struct packed {
    logic       clear;
    logic       step;
    logic [1:0] row;
    logic       dir;
    logic       in_range;
  } eval_ctrl_t;

  // Scale a value by the sample offset -3, -1, +1 or +3 eighths of a pixel
  function automatic logic signed [ACC_W-1:0] offset_scale(
    input logic signed [ACC_W-1:0] v,
    input logic [1:0]              idx
  );
    logic signed [ACC_W-1:0] r;
    case (idx)
      2'd0: begin
        r = -(v + (v <<< 1));
      end
      2'd1: begin
        r = -v;
      end
      2'd2: begin
        r = v;
      end
      default: begin
        r = v + (v <<< 1);
      end
    endcase
    return r <<< (FRACTION_BITS - 3);
  endfunction

endpackage

`default_nettype wire

/* rtl/gcr_edge_ram.sv */
`default_nettype none

module gcr_edge_ram (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [gcr_pkg::EDGE_AW-1:0]  wr_addr_i,
  input  wire gcr_pkg::edge_t               wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [gcr_pkg::EDGE_AW-1:0]  rd_addr_i,
  output gcr_pkg::edge_t                    rd_data_o
);

  gcr_pkg::edge_t edge_mem [gcr_pkg::EDGE_CAPACITY];
  gcr_pkg::edge_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      edge_mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= edge_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/gcr_mac.sv */
`default_nettype none

module gcr_mac (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic                               clr_i,
  input  wire logic signed [gcr_pkg::DIFF_W-1:0]  a_i,
  input  wire logic signed [gcr_pkg::DIFF_W-1:0]  b_i,
  output logic signed [gcr_pkg::ACC_W-1:0]        acc_o
);

  logic signed [2*gcr_pkg::DIFF_W-1:0] prod;
  logic signed [gcr_pkg::ACC_W-1:0]    acc_d, acc_q;

  // One product per cycle while en_i is high, added to the running sum or to zero
  assign prod  = a_i * b_i;
  assign acc_d = (clr_i ? '0 : acc_q) + gcr_pkg::ACC_W'(prod);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* rtl/gcr_sample_eval.sv */
`default_nettype none

module gcr_sample_eval (
  input  wire logic                               clk_i,
  input  wire gcr_pkg::eval_ctrl_t                ctrl_i,
  input  wire logic signed [gcr_pkg::ACC_W-1:0]   acc_i,
  input  wire logic signed [gcr_pkg::DIFF_W-1:0]  dx_i,
  input  wire logic signed [gcr_pkg::DIFF_W-1:0]  dy_i,
  output logic [gcr_pkg::COVER_W-1:0]             covered_o
);

  logic signed [gcr_pkg::WIND_W-1:0] wind_q [4][4];
  logic signed [gcr_pkg::ACC_W-1:0]  dx_ext, dy_ext, row_term;
  logic signed [gcr_pkg::ACC_W-1:0]  diff [4];
  logic [3:0]                        hit;
  logic signed [gcr_pkg::WIND_W-1:0] dir_step;

  assign dx_ext   = gcr_pkg::ACC_W'(dx_i);
  assign dy_ext   = gcr_pkg::ACC_W'(dy_i);
  assign row_term = gcr_pkg::offset_scale(dx_ext, ctrl_i.row);
  assign dir_step = ctrl_i.dir ? gcr_pkg::WIND_W'(1) : '1;

  // Crossing test for the four samples of the current row
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      diff[j] = acc_i + row_term - gcr_pkg::offset_scale(dy_ext, 2'(j));
      hit[j]  = (diff[j] <= 0);
    end
  end

  // Accumulate edge directions per sample
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        if (ctrl_i.clear) begin
          wind_q[r][j] <= '0;
        end else if (ctrl_i.step && ctrl_i.in_range && ctrl_i.row == 2'(r) && hit[j]) begin
          wind_q[r][j] <= wind_q[r][j] + dir_step;
        end
      end
    end
  end

  // Count samples with nonzero winding
  always_comb begin
    covered_o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        covered_o = covered_o + gcr_pkg::COVER_W'(wind_q[r][j] != '0);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/glyph_coverage_rasterizer.sv */
// Flow: one item at a time; a query walks every stored edge before its result reaches tvalid,
//   and tready returns once the result is registered.
//   Each stored edge costs one read, two passes through the single multiply-accumulate unit
//   and four sample-row evaluations.
// Reset (rst_ni low, asynchronous): edge store empty, no open contour, overflow clear,
//   origin shifts zero, output empty. Edge memory contents are not cleared.
`default_nettype none

module glyph_coverage_rasterizer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input item
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [15:0] point_x, [31:16] point_y, [41:32] pixel_col, [51:42] pixel_row, [55:52] zero
  input  wire logic [gcr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [1:0] operation
  input  wire logic [gcr_pkg::OP_W-1:0]            s_axis_tuser,
  input  wire logic                                s_axis_tlast,
  // Result item
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] coverage, [16:8] edges_held, [17] edge_overflow, [23:18] zero
  output logic [gcr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // Configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic                                cfg_index_i,
  input  wire logic [gcr_pkg::SHIFT_W-1:0]         cfg_data_i
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PT_A   = 4'd1;
  localparam logic [3:0] ST_PT_B   = 4'd2;
  localparam logic [3:0] ST_Q_INIT = 4'd3;
  localparam logic [3:0] ST_Q_RD   = 4'd4;
  localparam logic [3:0] ST_Q_MA   = 4'd5;
  localparam logic [3:0] ST_Q_MB   = 4'd6;
  localparam logic [3:0] ST_Q_EV   = 4'd7;
  localparam logic [3:0] ST_Q_FIN  = 4'd8;
  localparam logic [3:0] ST_RESP   = 4'd9;

  logic [3:0] state_q, state_d;

  logic                                in_accept;
  gcr_pkg::point_t                     pt_q, start_q, last_q;
  logic                                ends_q;
  logic [gcr_pkg::COL_W-1:0]           col_q, row_q;
  logic signed [gcr_pkg::SHIFT_W-1:0]  shift_x_q, shift_y_q;
  logic                                in_prog_q, ovf_q;
  logic [gcr_pkg::CNT_W-1:0]           total_q;
  logic [gcr_pkg::EDGE_AW-1:0]         e_q;
  logic [1:0]                          r_q;
  logic signed [gcr_pkg::SAMP_W-1:0]   sxc_q, syc_q, sxc_d, syc_d;
  logic signed [gcr_pkg::PIX_W-1:0]    pix_x, pix_y;
  logic [gcr_pkg::COV_W-1:0]           cov_q;
  logic                                m_valid_q;
  logic [gcr_pkg::OUT_TDATA_W-1:0]     m_data_q;

  // Edge insertion
  gcr_pkg::point_t  add_from, add_to;
  gcr_pkg::edge_t   wr_edge;
  logic             add_req, add_horiz, store_full, ram_wr_en, ovf_set;

  // Query datapath
  gcr_pkg::edge_t                      rd_edge;
  logic                                ram_rd_en;
  logic signed [gcr_pkg::DIFF_W-1:0]   dx, dy, mac_a, mac_b;
  logic                                mac_en, mac_clr;
  logic signed [gcr_pkg::ACC_W-1:0]    acc, sy_row, y0_ext, y1_ext;
  gcr_pkg::eval_ctrl_t                 eval_ctrl;
  logic [gcr_pkg::COVER_W-1:0]         covered;
  logic                                last_edge;
  logic [gcr_pkg::HELD_W-1:0]          held;
  logic                                out_free;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Pick the edge ends for the two insertion slots of an added point
  always_comb begin
    if (state_q == ST_PT_A) begin
      add_from = last_q;
      add_to   = pt_q;
      add_req  = in_prog_q;
    end else begin
      add_from = pt_q;
      add_to   = start_q;
      add_req  = (state_q == ST_PT_B) && ends_q;
    end
  end

  assign add_horiz     = (add_from.y == add_to.y);
  assign store_full    = (total_q >= gcr_pkg::CNT_W'(gcr_pkg::EDGE_CAPACITY));
  assign ram_wr_en     = add_req && !add_horiz && !store_full;
  assign ovf_set       = add_req && !add_horiz && store_full;
  assign wr_edge.rises = (add_from.y < add_to.y);
  assign wr_edge.upper = wr_edge.rises ? add_from : add_to;
  assign wr_edge.lower = wr_edge.rises ? add_to : add_from;

  gcr_edge_ram u_edge_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (total_q[gcr_pkg::EDGE_AW-1:0]),
    .wr_data_i (wr_edge),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (e_q),
    .rd_data_o (rd_edge)
  );

  assign ram_rd_en = (state_q == ST_Q_RD);

  // Edge deltas; dy is always positive for a stored edge
  assign dx = gcr_pkg::DIFF_W'(rd_edge.lower.x) - gcr_pkg::DIFF_W'(rd_edge.upper.x);
  assign dy = gcr_pkg::DIFF_W'(rd_edge.lower.y) - gcr_pkg::DIFF_W'(rd_edge.upper.y);

  // Shared multiplier: (x0 - sxc) * dy, then + (syc - y0) * dx
  always_comb begin
    if (state_q == ST_Q_MA) begin
      mac_a = gcr_pkg::DIFF_W'(rd_edge.upper.x) - gcr_pkg::DIFF_W'(sxc_q);
      mac_b = dy;
    end else begin
      mac_a = gcr_pkg::DIFF_W'(syc_q) - gcr_pkg::DIFF_W'(rd_edge.upper.y);
      mac_b = dx;
    end
  end

  assign mac_en  = (state_q == ST_Q_MA) || (state_q == ST_Q_MB);
  assign mac_clr = (state_q == ST_Q_MA);

  gcr_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .clr_i (mac_clr),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  // Sample row y against the half-open edge span
  assign sy_row = gcr_pkg::ACC_W'(syc_q) + gcr_pkg::offset_scale(gcr_pkg::ACC_ONE, r_q);
  assign y0_ext = gcr_pkg::ACC_W'(rd_edge.upper.y);
  assign y1_ext = gcr_pkg::ACC_W'(rd_edge.lower.y);

  assign eval_ctrl.clear    = (state_q == ST_Q_INIT);
  assign eval_ctrl.step     = (state_q == ST_Q_EV);
  assign eval_ctrl.row      = r_q;
  assign eval_ctrl.dir      = rd_edge.rises;
  assign eval_ctrl.in_range = (sy_row >= y0_ext) && (sy_row < y1_ext);

  gcr_sample_eval u_sample_eval (
    .clk_i     (clk_i),
    .ctrl_i    (eval_ctrl),
    .acc_i     (acc),
    .dx_i      (dx),
    .dy_i      (dy),
    .covered_o (covered)
  );

  assign last_edge = ((gcr_pkg::CNT_W'(e_q) + gcr_pkg::CNT_W'(1)) == total_q);

  // Sample grid centre in fixed point
  assign pix_x = signed'(gcr_pkg::PIX_W'(col_q)) + gcr_pkg::PIX_W'(shift_x_q);
  assign pix_y = signed'(gcr_pkg::PIX_W'(row_q)) + gcr_pkg::PIX_W'(shift_y_q);
  assign sxc_d = gcr_pkg::SAMP_W'(pix_x) <<< gcr_pkg::FRACTION_BITS;
  assign syc_d = gcr_pkg::SAMP_W'(pix_y) <<< gcr_pkg::FRACTION_BITS;

  assign held = (32'(total_q) > gcr_pkg::HELD_MAX) ? gcr_pkg::HELD_W'(gcr_pkg::HELD_MAX)
                                                   : gcr_pkg::HELD_W'(total_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            gcr_pkg::OP_ADD_POINT: state_d = ST_PT_A;
            gcr_pkg::OP_QUERY:     state_d = ST_Q_INIT;
            default:               state_d = ST_RESP;
          endcase
        end
      end
      ST_PT_A:   state_d = ST_PT_B;
      ST_PT_B:   state_d = ST_RESP;
      ST_Q_INIT: state_d = (total_q == '0) ? ST_Q_FIN : ST_Q_RD;
      ST_Q_RD:   state_d = ST_Q_MA;
      ST_Q_MA:   state_d = ST_Q_MB;
      ST_Q_MB:   state_d = ST_Q_EV;
      ST_Q_EV: begin
        if (r_q == 2'd3) begin
          state_d = last_edge ? ST_Q_FIN : ST_Q_RD;
        end
      end
      ST_Q_FIN:  state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control and outline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= '0;
      last_q    <= '0;
      in_prog_q <= 1'b0;
      ovf_q     <= 1'b0;
      total_q   <= '0;
      e_q       <= '0;
      r_q       <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Configuration writes
      if (cfg_valid_i) begin
        if (cfg_index_i == gcr_pkg::CFG_SHIFT_X) begin
          shift_x_q <= cfg_data_i;
        end else begin
          shift_y_q <= cfg_data_i;
        end
      end

      // Clear outline at acceptance
      if (in_accept && s_axis_tuser == gcr_pkg::OP_CLEAR) begin
        total_q   <= '0;
        start_q   <= '0;
        last_q    <= '0;
        in_prog_q <= 1'b0;
        ovf_q     <= 1'b0;
      end

      // Open a contour or append to it
      if (state_q == ST_PT_A) begin
        if (!in_prog_q) begin
          start_q   <= pt_q;
          in_prog_q <= 1'b1;
        end
        last_q <= pt_q;
      end
      if (state_q == ST_PT_B && ends_q) begin
        in_prog_q <= 1'b0;
      end
      if (ram_wr_en) begin
        total_q <= total_q + gcr_pkg::CNT_W'(1);
      end
      if (ovf_set) begin
        ovf_q <= 1'b1;
      end

      // Walk edges and sample rows
      if (state_q == ST_Q_INIT) begin
        e_q <= '0;
        r_q <= '0;
      end
      if (state_q == ST_Q_EV) begin
        r_q <= r_q + 2'd1;
        if (r_q == 2'd3) begin
          e_q <= e_q + gcr_pkg::EDGE_AW'(1);
        end
      end

      // Output register
      if (state_q == ST_RESP && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and result data
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pt_q.x <= s_axis_tdata[15:0];
      pt_q.y <= s_axis_tdata[31:16];
      col_q  <= s_axis_tdata[41:32];
      row_q  <= s_axis_tdata[51:42];
      ends_q <= s_axis_tlast;
      cov_q  <= '0;
    end
    if (state_q == ST_Q_INIT) begin
      sxc_q <= sxc_d;
      syc_q <= syc_d;
    end
    if (state_q == ST_Q_FIN) begin
      cov_q <= gcr_pkg::COV_W'(((13'(covered) << 8) - 13'(covered)) >> 4);
    end
    if (state_q == ST_RESP && out_free) begin
      m_data_q <= {6'd0, ovf_q, held, cov_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Edge count stays within the store
  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= gcr_pkg::CNT_W'(gcr_pkg::EDGE_CAPACITY))
    else $error("edge count above capacity");

  // Every stored edge advances the count by exactly one
  a_write_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_en |=> total_q == $past(total_q) + gcr_pkg::CNT_W'(1))
    else $error("edge write without count advance");

  // A result only appears out of the response state
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result raised outside response state");

  // The edge set is frozen while samples are evaluated
  a_query_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_EV) |=> $stable(total_q))
    else $error("edge count changed during query");

endmodule

`default_nettype wire
